// File: sv/periodic_nearest_site_search_unit_assert.svh
// Assertion macros for the periodic nearest-site search unit.
`ifndef PERIODIC_NEAREST_SITE_SEARCH_UNIT_ASSERT_SVH
`define PERIODIC_NEAREST_SITE_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PNS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PNS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PNS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PNS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/pnss_pkg.sv
// Shared types and constants for the periodic nearest-site search unit.
`timescale 1ns / 1ps
`default_nettype none
package pnss_pkg;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic [47:0] DIST_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] REG_BOX_X = 3'd0;
    localparam logic [2:0] REG_BOX_Y = 3'd1;
    localparam logic [2:0] REG_BOX_Z = 3'd2;
    localparam logic [2:0] REG_INV_X = 3'd3;
    localparam logic [2:0] REG_INV_Y = 3'd4;
    localparam logic [2:0] REG_INV_Z = 3'd5;
    localparam logic [2:0] REG_COUNT = 3'd6;

    typedef struct packed {
        logic               command;
        logic [7:0]         site_index;
        logic signed [23:0] coord_x;
        logic signed [23:0] coord_y;
        logic signed [23:0] coord_z;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  nearest_index;
        logic [47:0] nearest_dist2;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // axis sequencing of the shared distance unit
    typedef enum logic [2:0] {
        PH_READ,
        PH_MUL,
        PH_WRAP,
        PH_SQ,
        PH_ACC
    } phase_t;
endpackage
`default_nettype wire

// File: sv/periodic_nearest_site_search_unit.sv
// Top level: site table, config registers and sequencer for nearest-site search.
// A write word is taken when accepted; a query strobes its result once all N sites are searched,
// N = site_count clamped to MAX_SITES (each site is read from the table, then its x, y, z
// pass in turn through the one shared axis unit: multiply, wrap, square, accumulate).
// A new word is accepted only while busy is low; busy stays high through the result strobe.
// rst_n clears the registers and the sequencer; the site table is not cleared.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_nearest_site_search_unit_assert.svh"
module periodic_nearest_site_search_unit
    import pnss_pkg::*;
#(
    parameter int MAX_SITES = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [4:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    input  wire logic       start,
    output logic            busy,
    input  wire in_word_t   in_word,
    output logic            result_valid,
    output out_word_t       result
);
    localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int CW = $clog2(MAX_SITES + 1);

    logic [22:0] box_x_reg, box_y_reg, box_z_reg;
    logic [31:0] inv_x_reg, inv_y_reg, inv_z_reg;
    logic [8:0]  count_reg;

    logic [71:0] mem [MAX_SITES];
    logic [71:0] rd_reg;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [1:0]  axis_reg, axis_next;
    logic [CW-1:0] idx_reg, idx_next, limit_reg;
    logic [CW-1:0] limit_w;
    logic signed [23:0] qx_reg, qy_reg, qz_reg;
    logic [47:0] acc_reg, acc_next;
    logic        accsat_reg, accsat_next;
    logic [47:0] best_reg, best_next;
    logic [7:0]  besti_reg, besti_next;
    logic        rv_reg;

    logic signed [24:0] d_sel;
    logic [22:0]  box_sel;
    logic [31:0]  inv_sel;
    logic [47:0]  sq;
    logic         sat;
    logic [48:0]  sum;
    logic [47:0]  site_dist2;
    logic         accept, wr_cfg, last;

    assign pready = 1'b1;
    assign accept = start && !busy;
    assign wr_cfg = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg <= 23'd65536;
            box_y_reg <= 23'd65536;
            box_z_reg <= 23'd65536;
            inv_x_reg <= 32'd16777216;
            inv_y_reg <= 32'd16777216;
            inv_z_reg <= 32'd16777216;
            count_reg <= '0;
        end
        else if (wr_cfg)
        begin
            case (paddr[4:2])
                REG_BOX_X: box_x_reg <= pwdata[22:0];
                REG_BOX_Y: box_y_reg <= pwdata[22:0];
                REG_BOX_Z: box_z_reg <= pwdata[22:0];
                REG_INV_X: inv_x_reg <= pwdata;
                REG_INV_Y: inv_y_reg <= pwdata;
                REG_INV_Z: inv_z_reg <= pwdata;
                REG_COUNT: count_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[4:2])
            REG_BOX_X: prdata = {9'd0, box_x_reg};
            REG_BOX_Y: prdata = {9'd0, box_y_reg};
            REG_BOX_Z: prdata = {9'd0, box_z_reg};
            REG_INV_X: prdata = inv_x_reg;
            REG_INV_Y: prdata = inv_y_reg;
            REG_INV_Z: prdata = inv_z_reg;
            REG_COUNT: prdata = {23'd0, count_reg};
            default:   prdata = '0;
        endcase
    end

    // site table
    always_ff @(posedge clk)
    begin
        if (accept && in_word.command == CMD_WRITE && 32'(in_word.site_index) < MAX_SITES)
            mem[AW'(in_word.site_index)] <=
                {in_word.coord_x, in_word.coord_y, in_word.coord_z};
        rd_reg <= mem[idx_reg[AW-1:0]];
    end

    assign limit_w = (32'(count_reg) > MAX_SITES) ? CW'(MAX_SITES) : CW'(count_reg);

    // shared axis unit
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                d_sel = 25'($signed(rd_reg[71:48])) - 25'(qx_reg);
                box_sel = box_x_reg;
                inv_sel = inv_x_reg;
            end
            2'd1:
            begin
                d_sel = 25'($signed(rd_reg[47:24])) - 25'(qy_reg);
                box_sel = box_y_reg;
                inv_sel = inv_y_reg;
            end
            default:
            begin
                d_sel = 25'($signed(rd_reg[23:0])) - 25'(qz_reg);
                box_sel = box_z_reg;
                inv_sel = inv_z_reg;
            end
        endcase
    end

    pnss_axis_unit u_axis (
        .clk (clk),
        .d   (d_sel),
        .box (box_sel),
        .inv (inv_sel),
        .sq  (sq),
        .sat (sat)
    );

    assign sum  = 49'(acc_reg) + 49'(sq);
    assign site_dist2 = (accsat_reg || sat || sum[48]) ? DIST_MAX : sum[47:0];
    assign last = (idx_reg + CW'(1) >= limit_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && in_word.command == CMD_QUERY)
                state_next = (limit_w == '0) ? ST_DONE : ST_RUN;
            ST_RUN: if (phase_reg == PH_ACC && axis_reg == 2'd2 && last)
                state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer datapath
    always_comb
    begin
        phase_next  = phase_reg;
        axis_next   = axis_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        accsat_next = accsat_reg;
        best_next   = best_reg;
        besti_next  = besti_reg;
        case (state_reg)
            ST_IDLE:
            begin
                phase_next  = PH_READ;
                axis_next   = 2'd0;
                idx_next    = '0;
                acc_next    = '0;
                accsat_next = 1'b0;
                best_next   = DIST_MAX;
                besti_next  = '0;
            end
            ST_RUN:
            begin
                case (phase_reg)
                    PH_READ: phase_next = PH_MUL;
                    PH_MUL:  phase_next = PH_WRAP;
                    PH_WRAP: phase_next = PH_SQ;
                    PH_SQ:   phase_next = PH_ACC;
                    PH_ACC:
                    begin
                        if (axis_reg != 2'd2)
                        begin
                            acc_next    = sum[47:0];
                            accsat_next = accsat_reg || sat || sum[48];
                            axis_next   = axis_reg + 2'd1;
                            phase_next  = PH_MUL;
                        end
                        else
                        begin
                            if (idx_reg == '0 || site_dist2 < best_reg)
                            begin
                                best_next  = site_dist2;
                                besti_next = 8'(idx_reg);
                            end
                            acc_next    = '0;
                            accsat_next = 1'b0;
                            axis_next   = 2'd0;
                            idx_next    = idx_reg + CW'(1);
                            phase_next  = PH_READ;
                        end
                    end
                    default: phase_next = PH_READ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_READ;
            axis_reg   <= '0;
            idx_reg    <= '0;
            limit_reg  <= '0;
            acc_reg    <= '0;
            accsat_reg <= 1'b0;
            best_reg   <= DIST_MAX;
            besti_reg  <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            axis_reg   <= axis_next;
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
            accsat_reg <= accsat_next;
            best_reg   <= best_next;
            besti_reg  <= besti_next;
            rv_reg     <= (state_reg == ST_DONE);
            if (accept)
                limit_reg <= limit_w;
        end
    end

    // query point capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg <= in_word.coord_x;
            qy_reg <= in_word.coord_y;
            qz_reg <= in_word.coord_z;
        end
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != ST_IDLE) || rv_reg;
        result_valid = rv_reg;
        result.nearest_index = besti_reg;
        result.nearest_dist2 = best_reg;
    end

    `PNS_ASSERT_NXT(a_done_strobe, clk, rst_n, state_reg == ST_DONE, result_valid)
    `PNS_ASSERT_IMP(a_busy_result, clk, rst_n, result_valid, busy)
    `PNS_ASSERT_IMP(a_idx_range, clk, rst_n, state_reg == ST_RUN, idx_reg < limit_reg)
    `PNS_ASSERT_NXT(a_strobe_once, clk, rst_n, result_valid, !result_valid)
endmodule
`default_nettype wire

// File: sv/pnss_axis_unit.sv
// Shared per-axis wrap and square unit: multiplies, wraps, squares in three stages.
`timescale 1ns / 1ps
`default_nettype none
module pnss_axis_unit
    import pnss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [24:0] d,
    input  wire logic [22:0]        box,
    input  wire logic [31:0]        inv,
    output logic [47:0]             sq,
    output logic                    sat
);
    logic signed [58:0] prod_reg;
    logic signed [24:0] d1_reg;
    logic [22:0]        box1_reg;
    logic signed [59:0] p;
    logic signed [19:0] n;
    logic signed [44:0] w;
    logic signed [44:0] w_reg;
    logic [44:0]        mag;
    logic [23:0]        mag_reg;
    logic               big_reg;

    // stage 1: d * inv
    always_ff @(posedge clk)
    begin
        prod_reg <= 59'(d * $signed({1'b0, inv}));
        d1_reg   <= d;
        box1_reg <= box;
    end

    // stage 2: round to nearest image, wrap
    always_comb
    begin
        p = 60'(prod_reg) + (60'sd1 <<< 39);
        n = 20'(-(p >>> 40));
        w = 45'(d1_reg) + 45'(n * $signed({1'b0, box1_reg}));
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w;
    end

    // stage 3: magnitude and square
    always_comb
    begin
        mag = w_reg[44] ? 45'(-w_reg) : w_reg;
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag[23:0];
        big_reg <= (mag[44:24] != '0);
    end

    assign sq  = 48'(mag_reg) * 48'(mag_reg);
    assign sat = big_reg;
endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the periodic nearest-site search unit.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: holds its own copy of the site table and the box registers,
// predicts each query's answer and checks results in order.
class site_search_scoreboard;
    bit signed [23:0] site_x [256];
    bit signed [23:0] site_y [256];
    bit signed [23:0] site_z [256];
    bit [22:0] box [3];
    bit [31:0] inv [3];
    bit [8:0] count_reg;
    pnss_pkg::out_word_t answers [$];
    int mismatches;
    int checked;

    function new();
        for (int i = 0; i < 256; i++)
        begin
            site_x[i] = '0;
            site_y[i] = '0;
            site_z[i] = '0;
        end
        for (int a = 0; a < 3; a++)
        begin
            box[a] = 23'd65536;
            inv[a] = 32'd16777216;
        end
        count_reg = '0;
        mismatches = 0;
        checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            pnss_pkg::REG_BOX_X: box[0] = value[22:0];
            pnss_pkg::REG_BOX_Y: box[1] = value[22:0];
            pnss_pkg::REG_BOX_Z: box[2] = value[22:0];
            pnss_pkg::REG_INV_X: inv[0] = value;
            pnss_pkg::REG_INV_Y: inv[1] = value;
            pnss_pkg::REG_INV_Z: inv[2] = value;
            pnss_pkg::REG_COUNT: count_reg = value[8:0];
            default: ;
        endcase
    endfunction

    // minimum-image wrap of one axis, magnitude of the wrapped displacement
    function longint wrapped_mag(longint d, int axis);
        longint p;
        longint n;
        longint w;
        p = d * longint'({32'd0, inv[axis]}) + (longint'(1) <<< 39);
        n = p >>> 40;  // arithmetic shift gives the floor
        w = d - n * longint'({41'd0, box[axis]});
        return (w < 0) ? -w : w;
    endfunction

    function logic [47:0] wrapped_dist2(longint dx, longint dy, longint dz);
        longint mx;
        longint my;
        longint mz;
        longint s;
        mx = wrapped_mag(dx, 0);
        my = wrapped_mag(dy, 1);
        mz = wrapped_mag(dz, 2);
        if (mx > 64'hFF_FFFF || my > 64'hFF_FFFF || mz > 64'hFF_FFFF)
            return pnss_pkg::DIST_MAX;
        s = mx * mx + my * my + mz * mz;
        if (s > 64'hFFFF_FFFF_FFFF)
            return pnss_pkg::DIST_MAX;
        return s[47:0];
    endfunction

    // accepted input word: update the table or queue the expected answer
    function void note_word(pnss_pkg::in_word_t w);
        int n_sites;
        int best_i;
        logic [47:0] best_d;
        logic [47:0] d;
        pnss_pkg::out_word_t o;
        if (w.command == pnss_pkg::CMD_WRITE)
        begin
            site_x[w.site_index] = w.coord_x;
            site_y[w.site_index] = w.coord_y;
            site_z[w.site_index] = w.coord_z;
            return;
        end
        n_sites = (count_reg > 256) ? 256 : int'(count_reg);
        best_i = 0;
        best_d = pnss_pkg::DIST_MAX;
        for (int i = 0; i < n_sites; i++)
        begin
            d = wrapped_dist2(longint'(site_x[i]) - longint'(w.coord_x),
                              longint'(site_y[i]) - longint'(w.coord_y),
                              longint'(site_z[i]) - longint'(w.coord_z));
            if (i == 0 || d < best_d)
            begin
                best_d = d;
                best_i = i;
            end
        end
        o.nearest_index = best_i[7:0];
        o.nearest_dist2 = best_d;
        answers.push_back(o);
    endfunction

    function void check_result(pnss_pkg::out_word_t got);
        pnss_pkg::out_word_t exp_w;
        checked++;
        if (answers.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result index %0d dist2 %h",
                         got.nearest_index, got.nearest_dist2);
            return;
        end
        exp_w = answers.pop_front();
        if (got.nearest_index !== exp_w.nearest_index
            || got.nearest_dist2 !== exp_w.nearest_dist2)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: expected index %0d dist2 %h, got index %0d dist2 %h",
                         exp_w.nearest_index, exp_w.nearest_dist2,
                         got.nearest_index, got.nearest_dist2);
        end
    endfunction
endclass

module testbench;
    import pnss_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    in_word_t in_word = '0;
    logic result_valid;
    out_word_t result;

    site_search_scoreboard sb;
    int idle_pct;
    int n_writes;
    int n_queries;
    int n_phases;

    periodic_nearest_site_search_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .in_word(in_word),
        .result_valid(result_valid), .result(result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // results cannot be stalled, so check every strobe
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    // register write: setup cycle then access cycle
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // wait until the block has drained before touching registers
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.answers.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // send one word, with random idle cycles ahead of it
    task automatic send_word(in_word_t w);
        int gap;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_word(w);
        if (w.command == CMD_WRITE)
            n_writes++;
        else
            n_queries++;
    endtask

    function automatic in_word_t make_word(logic cmd, logic [7:0] idx,
                                           logic [23:0] x, logic [23:0] y,
                                           logic [23:0] z);
        in_word_t w;
        w.command = cmd;
        w.site_index = idx;
        w.coord_x = x;
        w.coord_y = y;
        w.coord_z = z;
        return w;
    endfunction

    // box length with matching reciprocal, now and then a random reciprocal
    task automatic set_axis(int axis, logic [22:0] len, bit odd_inv);
        logic [31:0] r;
        logic [63:0] q;
        q = (64'd1 << 40) / {41'd0, len};
        r = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        if (odd_inv)
            r = $urandom;
        case (axis)
            0:
            begin
                write_reg(REG_BOX_X, {9'd0, len});
                write_reg(REG_INV_X, r);
            end
            1:
            begin
                write_reg(REG_BOX_Y, {9'd0, len});
                write_reg(REG_INV_Y, r);
            end
            default:
            begin
                write_reg(REG_BOX_Z, {9'd0, len});
                write_reg(REG_INV_Z, r);
            end
        endcase
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(3))
            0: return 24'(24'h7F_FFFF - $urandom_range(3));
            1: return 24'(24'h80_0000 + $urandom_range(3));
            2: return 24'($urandom_range(20'hF_FFFF) - 24'h8_0000);
            default: return 24'($urandom);
        endcase
    endfunction

    initial
    begin
        int n_sites;
        int n_items;
        int p;
        logic [7:0] idx;
        sb = new();
        idle_pct = 17;
        n_writes = 0;
        n_queries = 0;
        n_phases = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no sites configured: index 0, all-ones distance
        send_word(make_word(CMD_QUERY, 8'd0, 24'h0, 24'h0, 24'h0));
        send_word(make_word(CMD_QUERY, 8'hFF, 24'h7F_FFFF, 24'h80_0000, 24'h0));

        // fill the whole table so any count reads written entries only
        for (int i = 0; i < 256; i++)
            send_word(make_word(CMD_WRITE, i[7:0], rand_coord(), rand_coord(),
                                rand_coord()));
        send_word(make_word(CMD_WRITE, 8'd0, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF));
        send_word(make_word(CMD_WRITE, 8'd1, 24'h80_0000, 24'h80_0000, 24'h80_0000));
        // sites 2 and 3 equal: a tie keeps the lower index
        send_word(make_word(CMD_WRITE, 8'd2, 24'h01_0000, 24'h02_0000, 24'h03_0000));
        send_word(make_word(CMD_WRITE, 8'd3, 24'h01_0000, 24'h02_0000, 24'h03_0000));

        for (p = 0; p < 9; p++)
        begin
            wait_idle();
            n_phases++;
            idle_pct = (p < 3) ? 17 : (p < 6) ? 80 : 0;
            case (p)
                0:
                begin
                    // unit box, wrap on every axis
                    n_sites = 16;
                    for (int a = 0; a < 3; a++)
                        set_axis(a, 23'd65536, 1'b0);
                end
                1:
                begin
                    // widest box with zero reciprocal: no wrap
                    n_sites = 5;
                    for (int a = 0; a < 3; a++)
                        set_axis(a, 23'h7F_FFFF, 1'b0);
                    write_reg(REG_INV_X, 32'd0);
                    write_reg(REG_INV_Y, 32'd0);
                    write_reg(REG_INV_Z, 32'd0);
                end
                2:
                begin
                    // narrowest box, largest reciprocal, whole table
                    n_sites = 256;
                    for (int a = 0; a < 3; a++)
                        set_axis(a, 23'd1, 1'b0);
                    write_reg(REG_INV_Y, 32'hFFFF_FFFF);
                end
                5:
                begin
                    // count beyond the table is clamped
                    n_sites = 511;
                    for (int a = 0; a < 3; a++)
                        set_axis(a, 23'($urandom_range(23'h7F_FFFF, 1)), 1'b0);
                end
                default:
                begin
                    n_sites = $urandom_range(32, 1);
                    for (int a = 0; a < 3; a++)
                        set_axis(a, 23'($urandom_range(23'h7F_FFFF, 1)),
                                 $urandom_range(3) == 0);
                end
            endcase
            write_reg(REG_COUNT, n_sites[31:0]);

            if (p == 0)
            begin
                send_word(make_word(CMD_QUERY, 8'd0, 24'h01_0000, 24'h02_0000,
                                    24'h03_0000));
                send_word(make_word(CMD_QUERY, 8'd0, 24'h7F_FFFF, 24'h7F_FFFF,
                                    24'h7F_FFFF));
                send_word(make_word(CMD_QUERY, 8'd0, 24'h80_0000, 24'h80_0000,
                                    24'h80_0000));
                send_word(make_word(CMD_QUERY, 8'd0, 24'h0, 24'h0, 24'h0));
            end

            n_items = (n_sites >= 256) ? 12 : 195;
            for (int k = 0; k < n_items; k++)
            begin
                // now and then a burst with no idle cycles
                if (k % 40 == 0 && p < 6)
                    idle_pct = ($urandom_range(3) == 0) ? 0
                             : (p < 3) ? 17 : 80;
                if ($urandom_range(99) < 60)
                begin
                    idx = ($urandom_range(1) == 0 && n_sites < 256)
                        ? 8'($urandom_range(n_sites - 1)) : 8'($urandom);
                    send_word(make_word(CMD_WRITE, idx, rand_coord(), rand_coord(),
                                        rand_coord()));
                end
                else
                    send_word(make_word(CMD_QUERY, 8'($urandom), rand_coord(),
                                        rand_coord(), rand_coord()));
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.answers.size() != 0)
            sb.mismatches += sb.answers.size();
        $display("Covered %0d site writes and %0d queries over %0d box settings,",
                 n_writes, n_queries, n_phases);
        $display("%0d results checked, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #200ms;
        $display("ERROR: timeout");
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+sv
sv/pnss_pkg.sv
sv/pnss_axis_unit.sv
sv/periodic_nearest_site_search_unit.sv
sim/testbench.sv
